[hdl/ets_pkg.sv]
// Shared constants for the eased tween sampler: field widths, easing mode codes
// and the default fraction width.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ets_pkg;

  localparam int VAL_W         = 32;  // signed Q16.16 values
  localparam int TIME_W        = 32;  // unsigned tick counts
  localparam int MODE_W        = 2;
  localparam int FRAC_BITS_DEF = 16;  // progress fraction width

  typedef logic [MODE_W-1:0] ease_mode_t;

  localparam ease_mode_t MODE_LINEAR     = 2'd0;
  localparam ease_mode_t MODE_EASE_OUT   = 2'd1;
  localparam ease_mode_t MODE_IN_OUT     = 2'd2;
  localparam ease_mode_t MODE_LINEAR_ALT = 2'd3;

endpackage

`default_nettype wire

[hdl/eased_tween_sampler_top.sv]
// Eased tween sampler: pipelined evaluation of one tween segment per request.
// Depends on ets_pkg (widths, easing mode codes, default fraction width).
//
// Usage:
//   Input channel (in_valid / in_ready) takes one request: start and end value
//   (signed Q16.16), start time, duration, easing mode and sample time (ticks).
//   Result channel (out_valid / out_ready) returns the interpolated value.
//   The pipeline runs the range checks, then the restoring divider (one
//   quotient bit per stage), then square, ease, scale multiply and final add.
//   Throughput is one request per cycle while the receiver takes results; the
//   divider stages set the depth and every stage takes a new request each
//   cycle that the pipeline advances.
//   A stalled receiver freezes the whole pipeline: in_ready drops in the same
//   cycle and every stage holds its request until out_ready returns.
//   Zero duration, a sample at or before start and a sample at or past the end
//   skip the arithmetic: the chosen endpoint rides down the pipeline instead.
//   Synchronous active-low reset clears all stage valid bits; payload
//   registers are left as they are.
`timescale 1ns / 1ps
`default_nettype none

module eased_tween_sampler_top #(
  parameter int FRAC_BITS = ets_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [ets_pkg::VAL_W-1:0]  in_start_value,
  input  wire logic signed [ets_pkg::VAL_W-1:0]  in_end_value,
  input  wire logic        [ets_pkg::TIME_W-1:0] in_start_time,
  input  wire logic        [ets_pkg::TIME_W-1:0] in_duration,
  input  wire logic        [ets_pkg::MODE_W-1:0] in_ease_mode,
  input  wire logic        [ets_pkg::TIME_W-1:0] in_now_time,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [ets_pkg::VAL_W-1:0]     out_value
);

  localparam int VW  = ets_pkg::VAL_W;
  localparam int TW  = ets_pkg::TIME_W;
  localparam int F   = FRAC_BITS;
  localparam int WW  = F + 1;          // progress including the value ONE
  localparam int SQW = 2 * WW;         // square of a progress value
  localparam int PW  = VW + WW;        // magnitude times progress

  localparam logic [WW-1:0] ONE_W = {1'b1, {F{1'b0}}};

  // Payload carried through range check and divider stages
  typedef struct packed {
    logic                         bypass;   // result is byp_val, skip math
    logic signed [VW-1:0]         byp_val;
    logic signed [VW-1:0]         start;
    logic        [VW-1:0]         mag;      // |end - start|
    logic                         neg;      // end below start
    ets_pkg::ease_mode_t          mode;
    logic        [TW-1:0]         dur;
    logic        [TW-1:0]         rem;      // partial remainder, below dur
    logic        [F-1:0]          q;        // quotient bits so far
  } div_t;

  typedef struct packed {
    logic                         bypass;
    logic signed [VW-1:0]         byp_val;
    logic signed [VW-1:0]         start;
    logic        [VW-1:0]         mag;
    logic                         neg;
    ets_pkg::ease_mode_t          mode;
    logic        [F-1:0]          t;
    logic        [SQW-1:0]        sq;
  } sqr_t;

  typedef struct packed {
    logic                         bypass;
    logic signed [VW-1:0]         byp_val;
    logic signed [VW-1:0]         start;
    logic        [VW-1:0]         mag;
    logic                         neg;
    logic        [WW-1:0]         w;        // eased progress, at most ONE
  } ease_t;

  typedef struct packed {
    logic                         bypass;
    logic signed [VW-1:0]         byp_val;
    logic signed [VW-1:0]         start;
    logic        [VW-1:0]         mag;
    logic                         neg;
    logic        [PW-1:0]         prod;
  } mul_t;

  // Whole pipeline advances together; a stalled receiver freezes it
  logic adv;

  logic              out_valid_r;
  logic signed [VW-1:0] out_value_r;

  div_t        div_r   [0:F];
  logic [F:0]  div_vld_r;
  sqr_t        sqr_r,  sqr_nxt;
  logic        sqr_vld_r;
  ease_t       ease_r, ease_nxt;
  logic        ease_vld_r;
  mul_t        mul_r,  mul_nxt;
  logic        mul_vld_r;
  logic signed [VW-1:0] value_nxt;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // ---------------------------------------------------------------------------
  // Stage 0: range checks, elapsed time and span magnitude
  // ---------------------------------------------------------------------------
  div_t            chk_nxt;
  logic [TW-1:0]   elapsed;
  logic [VW:0]     delta;
  logic [VW:0]     delta_abs;

  always_comb begin
    elapsed   = in_now_time - in_start_time;
    delta     = {in_end_value[VW-1], in_end_value} - {in_start_value[VW-1], in_start_value};
    delta_abs = delta[VW] ? (~delta + 1'b1) : delta;

    chk_nxt.start = in_start_value;
    chk_nxt.mag   = delta_abs[VW-1:0];
    chk_nxt.neg   = delta[VW];
    chk_nxt.mode  = in_ease_mode;
    chk_nxt.dur   = in_duration;
    chk_nxt.rem   = elapsed;
    chk_nxt.q     = '0;
    // Zero duration wins over every other check
    priority if (in_duration == '0) begin
      chk_nxt.bypass  = 1'b1;
      chk_nxt.byp_val = in_end_value;
    end else if (in_now_time <= in_start_time) begin
      chk_nxt.bypass  = 1'b1;
      chk_nxt.byp_val = in_start_value;
    end else if (elapsed >= in_duration) begin
      chk_nxt.bypass  = 1'b1;
      chk_nxt.byp_val = in_end_value;
    end else begin
      chk_nxt.bypass  = 1'b0;
      chk_nxt.byp_val = in_end_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1..F: restoring divider, one quotient bit per stage.
  // The remainder stays below dur, so the doubled remainder fits in TW+1 bits.
  // ---------------------------------------------------------------------------
  div_t          div_nxt  [1:F];
  logic [TW:0]   div_dbl  [1:F];
  logic [TW:0]   div_diff [1:F];
  logic [F:1]    div_ge;

  always_comb begin
    for (int i = 1; i <= F; i++) begin
      div_dbl[i]  = {div_r[i-1].rem, 1'b0};
      div_diff[i] = div_dbl[i] - {1'b0, div_r[i-1].dur};
      div_ge[i]   = (div_dbl[i] >= {1'b0, div_r[i-1].dur});

      div_nxt[i]     = div_r[i-1];
      div_nxt[i].rem = div_ge[i] ? div_diff[i][TW-1:0] : div_dbl[i][TW-1:0];
      div_nxt[i].q   = {div_r[i-1].q[F-2:0], div_ge[i]};
    end
  end

  // Advance the check stage and every divider stage together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld_r <= '0;
    end else if (adv) begin
      div_vld_r <= {div_vld_r[F-1:0], in_valid};
    end
    if (adv) begin
      div_r[0] <= chk_nxt;
      for (int i = 1; i <= F; i++) begin
        div_r[i] <= div_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Square stage: pick the operand for the easing curve and square it
  // ---------------------------------------------------------------------------
  logic [WW-1:0] t_ext;
  logic [WW-1:0] u;
  logic [WW-1:0] sq_op;

  always_comb begin
    t_ext = {1'b0, div_r[F].q};
    u     = ONE_W - t_ext;
    unique case (div_r[F].mode)
      ets_pkg::MODE_EASE_OUT: sq_op = u;
      ets_pkg::MODE_IN_OUT:   sq_op = div_r[F].q[F-1] ? u : t_ext;
      ets_pkg::MODE_LINEAR,
      ets_pkg::MODE_LINEAR_ALT: sq_op = '0;
      default:                sq_op = '0;
    endcase

    sqr_nxt.bypass  = div_r[F].bypass;
    sqr_nxt.byp_val = div_r[F].byp_val;
    sqr_nxt.start   = div_r[F].start;
    sqr_nxt.mag     = div_r[F].mag;
    sqr_nxt.neg     = div_r[F].neg;
    sqr_nxt.mode    = div_r[F].mode;
    sqr_nxt.t       = div_r[F].q;
    sqr_nxt.sq      = sq_op * sq_op;
  end

  // ---------------------------------------------------------------------------
  // Ease stage: scale the square and fold it into the eased progress
  // ---------------------------------------------------------------------------
  always_comb begin
    ease_nxt.bypass  = sqr_r.bypass;
    ease_nxt.byp_val = sqr_r.byp_val;
    ease_nxt.start   = sqr_r.start;
    ease_nxt.mag     = sqr_r.mag;
    ease_nxt.neg     = sqr_r.neg;
    unique case (sqr_r.mode)
      ets_pkg::MODE_EASE_OUT: ease_nxt.w = ONE_W - sqr_r.sq[F +: WW];
      // Doubling the square is a shift by one bit less
      ets_pkg::MODE_IN_OUT:   ease_nxt.w = sqr_r.t[F-1] ? (ONE_W - sqr_r.sq[F-1 +: WW])
                                                        : sqr_r.sq[F-1 +: WW];
      ets_pkg::MODE_LINEAR,
      ets_pkg::MODE_LINEAR_ALT: ease_nxt.w = {1'b0, sqr_r.t};
      default:                ease_nxt.w = {1'b0, sqr_r.t};
    endcase
  end

  // ---------------------------------------------------------------------------
  // Multiply stage: span magnitude times eased progress
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_nxt.bypass  = ease_r.bypass;
    mul_nxt.byp_val = ease_r.byp_val;
    mul_nxt.start   = ease_r.start;
    mul_nxt.mag     = ease_r.mag;
    mul_nxt.neg     = ease_r.neg;
    mul_nxt.prod    = PW'(ease_r.mag) * PW'(ease_r.w);
  end

  // ---------------------------------------------------------------------------
  // Final stage: step from start toward end; the step never exceeds the span,
  // so plain wrapping arithmetic gives the exact result
  // ---------------------------------------------------------------------------
  logic [VW-1:0] step;

  always_comb begin
    step = mul_r.prod[F +: VW];
    if (mul_r.bypass) begin
      value_nxt = mul_r.byp_val;
    end else if (mul_r.neg) begin
      value_nxt = mul_r.start - $signed(step);
    end else begin
      value_nxt = mul_r.start + $signed(step);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqr_vld_r   <= 1'b0;
      ease_vld_r  <= 1'b0;
      mul_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      sqr_vld_r   <= div_vld_r[F];
      ease_vld_r  <= sqr_vld_r;
      mul_vld_r   <= ease_vld_r;
      out_valid_r <= mul_vld_r;
    end
    if (adv) begin
      sqr_r       <= sqr_nxt;
      ease_r      <= ease_nxt;
      mul_r       <= mul_nxt;
      out_value_r <= value_nxt;
    end
  end

`ifndef SYNTHESIS
  // Divider keeps its remainder below the divisor for live requests
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    div_vld_r[F] && !div_r[F].bypass |-> div_r[F].rem < div_r[F].dur)
    else $error("divider remainder not below duration");

  // Eased progress never passes ONE
  a_ease_range: assert property (@(posedge clk) disable iff (!rst_n)
    ease_vld_r && !ease_r.bypass |-> ease_r.w <= ONE_W)
    else $error("eased progress above one");

  // Step never exceeds the span, so the result stays between the endpoints
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    mul_vld_r && !mul_r.bypass |-> mul_r.prod[F +: VW] <= mul_r.mag)
    else $error("interpolation step exceeds span");

  // A stall freezes the last multiply stage along with the output
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> mul_vld_r == $past(mul_vld_r))
    else $error("pipeline advanced during stall");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for eased_tween_sampler_top: directed endpoint, extreme
// and easing cases, then random tween requests with random idling on both sides.
// Depends on ets_pkg and the eased_tween_sampler_top RTL.
`timescale 1ns / 1ps

module tb;

  localparam int FRAC     = ets_pkg::FRAC_BITS_DEF;
  localparam int PIPE_LAT = FRAC + 5;  // pipeline register depth of the top level, range check through output
  localparam longint unsigned ONE  = 64'd1 << FRAC;
  localparam longint unsigned HALF = ONE >> 1;

  // Q16.16 shorthands for the directed cases
  localparam logic signed [ets_pkg::VAL_W-1:0] Q_NEG3  = 32'shFFFD_0000;
  localparam logic signed [ets_pkg::VAL_W-1:0] Q_POS5  = 32'sh0005_0000;
  localparam logic signed [ets_pkg::VAL_W-1:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [ets_pkg::VAL_W-1:0] Q_NEG2  = 32'shFFFE_0000;
  localparam logic signed [ets_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ets_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic [ets_pkg::TIME_W-1:0]       T_MAX   = 32'hFFFF_FFFF;

  typedef struct {
    logic signed [ets_pkg::VAL_W-1:0] value;
    int unsigned                      tag;
  } tween_expect_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic signed [ets_pkg::VAL_W-1:0]  in_start_value;
  logic signed [ets_pkg::VAL_W-1:0]  in_end_value;
  logic [ets_pkg::TIME_W-1:0]        in_start_time;
  logic [ets_pkg::TIME_W-1:0]        in_duration;
  logic [ets_pkg::MODE_W-1:0]        in_ease_mode;
  logic [ets_pkg::TIME_W-1:0]        in_now_time;
  logic                              out_valid;
  logic                              out_ready;
  logic signed [ets_pkg::VAL_W-1:0]  out_value;

  // Values still owed by the pipeline, oldest first
  tween_expect_t pending_values[$];

  int unsigned requests_taken;
  int unsigned values_checked;
  int unsigned error_count;
  int unsigned mode_hits[4];
  bit          sender_idles = 1'b1;
  bit          sink_stalls  = 1'b1;

  eased_tween_sampler_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_value (in_start_value),
    .in_end_value   (in_end_value),
    .in_start_time  (in_start_time),
    .in_duration    (in_duration),
    .in_ease_mode   (in_ease_mode),
    .in_now_time    (in_now_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run, with every request and every
  // result stalled to the maximum.
  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d values still pending", $realtime, pending_values.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Interpolated value for one tween sample. All math is done in 64 bits so the
  // span end - start never wraps and the progress fraction keeps full range.
  function automatic logic signed [ets_pkg::VAL_W-1:0] predict_tween(
    input logic signed [ets_pkg::VAL_W-1:0] from_val,
    input logic signed [ets_pkg::VAL_W-1:0] to_val,
    input logic [ets_pkg::TIME_W-1:0]       t_start,
    input logic [ets_pkg::TIME_W-1:0]       t_len,
    input ets_pkg::ease_mode_t              mode,
    input logic [ets_pkg::TIME_W-1:0]       t_now
  );
    longint          from_l;
    longint          to_l;
    longint          span;
    longint          res;
    longint unsigned elapsed;
    longint unsigned prog;
    longint unsigned weight;
    longint unsigned rem;
    longint unsigned mag;
    longint unsigned stride;
    from_l = from_val;
    to_l   = to_val;
    // Zero duration wins over every other check
    if (t_len == '0) begin
      res = to_l;
    end else if (t_now <= t_start) begin
      // Times are not modular: a sample numerically below start is "before"
      res = from_l;
    end else begin
      elapsed = longint'(t_now) - longint'(t_start);
      if (elapsed >= longint'(t_len)) begin
        res = to_l;
      end else begin
        prog = (elapsed << FRAC) / longint'(t_len);
        case (mode)
          ets_pkg::MODE_EASE_OUT: begin
            rem    = ONE - prog;
            weight = ONE - ((rem * rem) >> FRAC);
          end
          ets_pkg::MODE_IN_OUT: begin
            if (prog < HALF) begin
              weight = (2 * prog * prog) >> FRAC;
            end else begin
              rem    = ONE - prog;
              weight = ONE - ((2 * rem * rem) >> FRAC);
            end
          end
          // Linear and its alternate code behave the same
          default: weight = prog;
        endcase
        span   = to_l - from_l;
        mag    = (span < 0) ? longint'(-span) : longint'(span);
        stride = (mag * weight) >> FRAC;
        res    = (span < 0) ? from_l - longint'(stride) : from_l + longint'(stride);
      end
    end
    return res[ets_pkg::VAL_W-1:0];
  endfunction

  // Scoreboard: retire results first, then record the request taken this edge.
  // Both live in one process so their relative order is fixed.
  always @(posedge clk) begin
    tween_expect_t head;
    tween_expect_t fresh;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_values.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result: expected none actual %h", $realtime, out_value);
        end else begin
          head = pending_values.pop_front();
          values_checked++;
          if (out_value !== head.value) begin
            error_count++;
            $display("%0t: value mismatch on request %0d: expected %h actual %h",
                     $realtime, head.tag, head.value, out_value);
          end
        end
      end
      if (in_valid && in_ready) begin
        fresh.value = predict_tween(in_start_value, in_end_value, in_start_time,
                                    in_duration, in_ease_mode, in_now_time);
        fresh.tag   = requests_taken;
        pending_values.insert(pending_values.size(), fresh);
        requests_taken++;
        mode_hits[in_ease_mode]++;
      end
    end
  end

  // Result side: stall in random bursts while enabled, otherwise keep ready high.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_stalls && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Present one request; called at a falling edge, returns at a falling edge
  // with valid still high so back-to-back requests never drop it.
  task automatic send_request(
    input logic signed [ets_pkg::VAL_W-1:0] from_val,
    input logic signed [ets_pkg::VAL_W-1:0] to_val,
    input logic [ets_pkg::TIME_W-1:0]       t_start,
    input logic [ets_pkg::TIME_W-1:0]       t_len,
    input ets_pkg::ease_mode_t              mode,
    input logic [ets_pkg::TIME_W-1:0]       t_now
  );
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_start_value <= from_val;
    in_end_value   <= to_val;
    in_start_time  <= t_start;
    in_duration    <= t_len;
    in_ease_mode   <= mode;
    in_now_time    <= t_now;
    // Hold the request until the block takes it
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed value has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_endpoint_cases();
    // Zero duration jumps to end, even with the sample before start
    send_request(Q_ONE, Q_NEG2, 32'd100, 32'd0, ets_pkg::MODE_LINEAR, 32'd500);
    send_request(Q_ONE, Q_NEG2, 32'd100, 32'd0, ets_pkg::MODE_EASE_OUT, 32'd5);
    // Sample exactly at start and numerically before start
    send_request(Q_NEG3, Q_POS5, 32'd1000, 32'd100, ets_pkg::MODE_IN_OUT, 32'd1000);
    send_request(Q_NEG3, Q_POS5, T_MAX, T_MAX, ets_pkg::MODE_LINEAR, 32'd0);
    // Sample exactly at the end and far past it
    send_request(Q_NEG3, Q_POS5, 32'd1000, 32'd100, ets_pkg::MODE_EASE_OUT, 32'd1100);
    send_request(Q_POS5, Q_NEG3, 32'd0, 32'd5, ets_pkg::MODE_IN_OUT, T_MAX);
  endtask

  task automatic test_field_extremes();
    // Full-scale spans in both directions, at the midpoint and near either end
    send_request(VAL_MIN, VAL_MAX, 32'd0, 32'd2, ets_pkg::MODE_LINEAR, 32'd1);
    send_request(VAL_MAX, VAL_MIN, 32'd0, 32'd2, ets_pkg::MODE_EASE_OUT, 32'd1);
    send_request(VAL_MIN, VAL_MAX, 32'd0, T_MAX, ets_pkg::MODE_IN_OUT, 32'hFFFF_FFFE);
    send_request(VAL_MAX, VAL_MIN, 32'd0, T_MAX, ets_pkg::MODE_EASE_OUT, 32'd1);
    send_request(VAL_MIN, VAL_MAX, 32'hFFFF_FFFE, T_MAX, ets_pkg::MODE_LINEAR_ALT, T_MAX);
    // Progress one step below the in-out knee
    send_request(VAL_MAX, VAL_MIN, 32'h8000_0000, 32'd131072, ets_pkg::MODE_IN_OUT,
                 32'h8000_FFFF);
  endtask

  task automatic test_ease_modes();
    // Quarter, half and three-quarter progress in every mode
    for (int m = 0; m < 4; m++) begin
      for (int q = 1; q < 4; q++) begin
        send_request(Q_NEG3, Q_POS5, 32'h0F00_0000, 32'd4, ets_pkg::ease_mode_t'(m),
                     32'h0F00_0000 + q);
      end
    end
  endtask

  // One random request: mostly in-range samples, the rest raw noise.
  task automatic send_random_request();
    logic signed [ets_pkg::VAL_W-1:0] from_val;
    logic signed [ets_pkg::VAL_W-1:0] to_val;
    logic [ets_pkg::TIME_W-1:0]       t_start;
    logic [ets_pkg::TIME_W-1:0]       t_len;
    logic [ets_pkg::TIME_W-1:0]       t_off;
    ets_pkg::ease_mode_t              mode;
    from_val = $urandom;
    to_val   = $urandom;
    mode     = ets_pkg::ease_mode_t'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0: begin
        from_val = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        to_val   = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      end
      1: to_val = from_val;
      2: begin
        from_val = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
        to_val   = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
      end
      default: ;
    endcase
    if ($urandom_range(0, 9) < 8) begin
      // Well formed: sample lands inside [start, start + duration]
      case ($urandom_range(0, 2))
        0:       t_len = $urandom_range(1, 64);
        1:       t_len = $urandom_range(1, 32'h0001_0000);
        default: t_len = $urandom_range(1, T_MAX);
      endcase
      t_start = $urandom_range(0, T_MAX - t_len);
      t_off   = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? t_len : '0)
                                            : $urandom_range(1, t_len);
      send_request(from_val, to_val, t_start, t_len, mode, t_start + t_off);
    end else begin
      t_len = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
      send_request(from_val, to_val, $urandom, t_len, mode, $urandom);
    end
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 900; i++) begin
      // Halfway through, hold off until the pipeline is empty
      if (i == 450) drain_results();
      // Run the tail at full rate on both sides
      if (i == 760) begin
        sender_idles = 1'b0;
        sink_stalls  = 1'b0;
      end
      send_random_request();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_start_value = '0;
    in_end_value   = '0;
    in_start_time  = '0;
    in_duration    = '0;
    in_ease_mode   = ets_pkg::MODE_LINEAR;
    in_now_time    = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_endpoint_cases();
    test_field_extremes();
    test_ease_modes();
    test_random_traffic();

    // Let the pipeline empty, then watch a while for stray results
    drain_results();
    repeat (2 * PIPE_LAT) @(posedge clk);

    $display("Checked %0d of %0d tween requests (linear %0d, ease-out %0d, in-out %0d, alt %0d),",
             values_checked, requests_taken, mode_hits[0], mode_hits[1], mode_hits[2],
             mode_hits[3]);
    $display("including endpoint, zero-duration and full-scale span cases; %0d errors.",
             error_count);
    if (error_count == 0 && pending_values.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
